FILE: hw/rtl/p2mcc_pkg.sv
// Package for the parameter to MIDI controller encoder: types, constants, mapping table.
`default_nettype none

package p2mcc_pkg;

	localparam int NUM_PARAMS  = 161;
	localparam int IDX_W       = 8;
	localparam int LEVEL_W     = 16;
	localparam int CACHE_W     = 14;

	localparam logic [LEVEL_W-1:0] FULL_SCALE  = 16'd32768;
	localparam logic [LEVEL_W-1:0] HALF_SCALE  = 16'd16384;
	localparam logic [IDX_W-1:0]   AUX_FIRST   = 8'd144;
	localparam logic [IDX_W-1:0]   AUX_LAST    = 8'd153;
	localparam logic [6:0]         AUX_CC      = 7'd96;
	localparam logic [2:0]         AUX_CHANNEL = 3'd5;

	// configuration register indexes
	localparam logic CFG_PORT_ONE = 1'b0;
	localparam logic CFG_PORT_TWO = 1'b1;

	// input opcodes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		KIND_FADER,
		KIND_MUTE,
		KIND_AUX,
		KIND_JOY
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] channel;
		logic [6:0] cc;
		logic       port2;
	} map_t;

	typedef struct packed {
		logic       last;
		logic [6:0] value;
		logic [6:0] cc;
		logic [4:0] channel;
		logic       port;
	} msg_t;

	// fixed console mapping; only meaningful for idx below NUM_PARAMS
	function automatic map_t map_lookup(input logic [IDX_W-1:0] idx);
		map_t m;
		logic [IDX_W-1:0] d;
		m = '{kind: KIND_JOY, channel: 3'd0, cc: 7'd0, port2: 1'b0};
		d = '0;
		if (idx < 8'd24) begin
			d = idx;
			m = '{kind: KIND_FADER, channel: 3'd1, cc: 7'(d << 1), port2: 1'b0};
		end else if (idx < 8'd36) begin
			d = idx - 8'd24;
			m = '{kind: KIND_FADER, channel: 3'd2, cc: 7'(d << 1), port2: 1'b1};
		end else if (idx < 8'd60) begin
			d = idx - 8'd36;
			m = '{kind: KIND_FADER, channel: 3'd1, cc: 7'(8'd48 + (d << 1)), port2: 1'b0};
		end else if (idx < 8'd72) begin
			d = idx - 8'd60;
			m = '{kind: KIND_FADER, channel: 3'd2, cc: 7'(8'd24 + (d << 1)), port2: 1'b1};
		end else if (idx < 8'd96) begin
			d = idx - 8'd72;
			m = '{kind: KIND_MUTE, channel: 3'd3, cc: 7'(d), port2: 1'b0};
		end else if (idx < 8'd108) begin
			d = idx - 8'd96;
			m = '{kind: KIND_MUTE, channel: 3'd4, cc: 7'(d), port2: 1'b1};
		end else if (idx < 8'd132) begin
			d = idx - 8'd108;
			m = '{kind: KIND_MUTE, channel: 3'd3, cc: 7'(8'd24 + d), port2: 1'b0};
		end else if (idx < AUX_FIRST) begin
			d = idx - 8'd132;
			m = '{kind: KIND_MUTE, channel: 3'd4, cc: 7'(8'd12 + d), port2: 1'b1};
		end else if (idx <= AUX_LAST) begin
			m = '{kind: KIND_AUX, channel: AUX_CHANNEL, cc: AUX_CC, port2: 1'b1};
		end else begin
			unique case (idx)
				8'd154:  m = '{kind: KIND_JOY, channel: 3'd2, cc: 7'd48, port2: 1'b1};
				8'd155:  m = '{kind: KIND_JOY, channel: 3'd2, cc: 7'd50, port2: 1'b1};
				8'd156:  m = '{kind: KIND_MUTE, channel: 3'd4, cc: 7'd24, port2: 1'b1};
				8'd157:  m = '{kind: KIND_JOY, channel: 3'd2, cc: 7'd52, port2: 1'b1};
				8'd158:  m = '{kind: KIND_JOY, channel: 3'd2, cc: 7'd54, port2: 1'b1};
				8'd159:  m = '{kind: KIND_MUTE, channel: 3'd4, cc: 7'd26, port2: 1'b1};
				8'd160:  m = '{kind: KIND_FADER, channel: 3'd5, cc: 7'd0, port2: 1'b1};
				default: m = '{kind: KIND_JOY, channel: 3'd0, cc: 7'd0, port2: 1'b0};
			endcase
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/p2mcc_ram.sv
// Generic single-clock RAM, one write port, one registered read port (read-first).
`default_nettype none

module p2mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/parameter_to_midi_cc_encoder_top.sv
// Top level of the parameter to MIDI controller encoder.
// An input beat passes the stage-1 registers (cache read), then the output register, before its first output beat.
// Throughput: one item per cycle for single messages while m_tready holds; a fader pair holds the output
// register pair until both of its beats are taken, so the next sent item waits for the second beat.
// Reset: asynchronous; closes both ports and marks every cache entry unsent at once
// through per-entry valid flops, so no clearing pass is needed.
`default_nettype none

module parameter_to_midi_cc_encoder_top
	import p2mcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [7:0] param_index, [23:8] level
	input  wire logic        s_tuser,   // [0] opcode
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [0] out_port, [5:1] midi_channel,
	                                    // [12:6] controller_number,
	                                    // [19:13] controller_value, [23:20] zero
	output logic             m_tlast,   // last_of_run
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data
);

	// configuration
	logic port_one_q, port_two_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_one_q <= 1'b0;
			port_two_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PORT_ONE: port_one_q <= cfg_data;
				CFG_PORT_TWO: port_two_q <= cfg_data;
			endcase
		end
	end

	// input decode and scaling
	logic [IDX_W-1:0]   in_idx;
	logic [LEVEL_W-1:0] in_lvl, lvl_c;
	logic [28:0]        prod14;
	logic [21:0]        prod7;

	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_lvl = s_tdata[IDX_W +: LEVEL_W];
	assign lvl_c  = (in_lvl > FULL_SCALE) ? FULL_SCALE : in_lvl;
	assign prod14 = 29'(lvl_c) * 29'd16383;
	assign prod7  = 22'(lvl_c) * 22'd127;

	// stage 1: cache data arrives, decision and write-back
	logic               valid_s1;
	logic               clear_s1;
	logic               inrange_s1;
	logic [IDX_W-1:0]   idx_s1;
	map_t               map_s1;
	logic [CACHE_W-1:0] v14_s1;
	logic [6:0]         v7_s1;
	logic               on_s1;

	logic               s_beat;
	logic               s1_go;
	logic               ob_free;

	assign s_beat   = s_tvalid & s_tready;
	assign s_tready = !valid_s1 | s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			clear_s1   <= (s_tuser == OP_CLEAR);
			inrange_s1 <= (in_idx < IDX_W'(NUM_PARAMS));
			idx_s1     <= in_idx;
			map_s1     <= map_lookup(in_idx);
			v14_s1     <= prod14[28:15];
			v7_s1      <= prod7[21:15];
			on_s1      <= (lvl_c > HALF_SCALE);
		end
	end

	// cache memory; a stalled item re-reads its own entry
	logic [IDX_W-1:0]   ram_raddr;
	logic [CACHE_W-1:0] ram_rdata;
	logic               wr_en;
	logic [CACHE_W-1:0] new_val;

	assign ram_raddr = (valid_s1 && !s1_go) ? idx_s1 : in_idx;

	p2mcc_ram #(
		.WIDTH (CACHE_W),
		.DEPTH (NUM_PARAMS)
	) u_cache (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (new_val),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write of the previous cycle is not yet visible in the read data
	logic               fwd_en_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	logic [CACHE_W-1:0] fwd_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q <= idx_s1;
		fwd_val_q <= new_val;
	end

	logic [NUM_PARAMS-1:0] cache_vld_q;
	logic [CACHE_W-1:0]    cached;
	logic                  entry_vld;
	logic [3:0]            aux_ofs;
	logic [4:0]            aux_code;
	logic                  repeat_hit;
	logic                  do_write;
	logic                  port_open;
	logic                  send;
	logic                  is_fader;

	assign cached    = (fwd_en_q && fwd_idx_q == idx_s1) ? fwd_val_q : ram_rdata;
	assign entry_vld = inrange_s1 & cache_vld_q[idx_s1];
	assign aux_ofs   = 4'(idx_s1 - AUX_FIRST);
	assign aux_code  = 5'({aux_ofs, 1'b0}) + (on_s1 ? 5'd3 : 5'd2);
	assign is_fader  = (map_s1.kind == KIND_FADER);

	always_comb begin
		unique case (map_s1.kind)
			KIND_FADER: new_val = v14_s1;
			KIND_MUTE:  new_val = on_s1 ? CACHE_W'(3) : CACHE_W'(2);
			KIND_AUX:   new_val = CACHE_W'(aux_code);
			KIND_JOY:   new_val = CACHE_W'(v7_s1);
		endcase
	end

	// aux mutes are never suppressed as repeats
	assign repeat_hit = entry_vld & (cached == new_val) & (map_s1.kind != KIND_AUX);
	assign do_write   = valid_s1 & !clear_s1 & inrange_s1 & !repeat_hit;
	assign port_open  = map_s1.port2 ? port_two_q : port_one_q;
	assign send       = do_write & port_open;
	assign s1_go      = valid_s1 & (!send | ob_free);
	assign wr_en      = s1_go & do_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_vld_q <= '0;
		end else if (s1_go && clear_s1) begin
			cache_vld_q <= '0;
		end else if (wr_en) begin
			cache_vld_q[idx_s1] <= 1'b1;
		end
	end

	// output register pair
	logic ob_valid_q, ob_second_q;
	msg_t msg0_q, msg1_q;
	msg_t msg0_d, msg1_d;
	logic m_beat;

	assign m_beat  = m_tvalid & m_tready;
	assign ob_free = !ob_valid_q | (m_tready & !ob_second_q);

	always_comb begin
		msg0_d.port    = map_s1.port2;
		msg0_d.channel = {2'b00, map_s1.channel};
		msg0_d.cc      = map_s1.cc;
		msg0_d.value   = is_fader ? v14_s1[13:7] : new_val[6:0];
		msg0_d.last    = !is_fader;
		msg1_d.port    = map_s1.port2;
		msg1_d.channel = {2'b00, map_s1.channel};
		msg1_d.cc      = map_s1.cc + 7'd1;
		msg1_d.value   = v14_s1[6:0];
		msg1_d.last    = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q  <= 1'b0;
			ob_second_q <= 1'b0;
		end else if (s1_go && send) begin
			ob_valid_q  <= 1'b1;
			ob_second_q <= is_fader;
		end else if (m_beat) begin
			ob_valid_q  <= ob_second_q;
			ob_second_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && send) begin
			msg0_q <= msg0_d;
			msg1_q <= msg1_d;
		end else if (m_beat && ob_second_q) begin
			msg0_q <= msg1_q;
		end
	end

	assign m_tvalid = ob_valid_q;
	assign m_tdata  = {4'b0000, msg0_q.value, msg0_q.cc, msg0_q.channel, msg0_q.port};
	assign m_tlast  = msg0_q.last;

endmodule

`default_nettype wire
